// ----- rtl/buddy_block_allocator_core_defines.svh -----
// Assertion macros shared by the checker files of the buddy allocator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bba_pkg.sv -----
// Shared constants of the buddy block allocator.
// No dependencies; imported by the core, the node unit and the checker.
`timescale 1ns / 1ps

package bba_pkg;

    // Default pool size exponent: the pool holds 2^MAX_ORDER units.
    localparam int BBA_MAX_ORDER = 10;

    // Command codes carried in the input tuser.
    localparam logic BBA_CMD_ALLOC = 1'b0;
    localparam logic BBA_CMD_FREE  = 1'b1;

    // Status codes carried in the output tuser.
    localparam logic BBA_ST_OK    = 1'b0;
    localparam logic BBA_ST_NOSPC = 1'b1;

endpackage

// ----- rtl/bba_node_calc.sv -----
// Shared index unit: maps a block (order, address) to its node in the free-map tree.
// Depends on bba_pkg for the default pool size.
`timescale 1ns / 1ps

module bba_node_calc
    import bba_pkg::*;
#(
    parameter int MAX_ORDER = BBA_MAX_ORDER
) (
    input  logic [$clog2(MAX_ORDER+2)-1:0] i_order,
    input  logic [MAX_ORDER-1:0]           i_addr,
    output logic [MAX_ORDER:0]             o_node
);

    localparam int OW = $clog2(MAX_ORDER + 2);
    localparam int NW = MAX_ORDER + 1;

    logic [OW-1:0] w_level;
    logic [NW-1:0] w_base;
    logic [NW-1:0] w_off;

    // Level counts down from the root; the first node of a level is 2^level - 1.
    always_comb begin
        w_level = OW'(MAX_ORDER) - i_order;
        w_base  = (NW'(1) << w_level) - NW'(1);
        w_off   = NW'(i_addr) >> i_order;
        o_node  = w_base + w_off;
    end

endmodule

// ----- rtl/buddy_block_allocator_core.sv -----
// Buddy block allocator: one item per command, walked bit by bit through the free map.
// Allocate probes free-map bits from the requested order upward, reading then checking each,
// splits the taken block down, then loads the result; free checks each buddy and merges
// while it is free, possibly up to the whole pool, then loads the result.
// Throughput: one item at a time; the input is ready only while the sequencer is idle.
// Reset: synchronous active-low; a clearing pass over the free map frees only the pool.
`timescale 1ns / 1ps

module buddy_block_allocator_core
    import bba_pkg::*;
#(
    parameter int MAX_ORDER = BBA_MAX_ORDER
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // request_size [MAX_ORDER:0], block_address [2*MAX_ORDER:MAX_ORDER+1], zero pad
    input  logic [((2*MAX_ORDER+1+7)/8)*8-1:0]      i_s_tdata,
    // command [0]
    input  logic                                    i_s_tuser,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // granted_address [MAX_ORDER-1:0], zero pad
    output logic [((MAX_ORDER+7)/8)*8-1:0]          o_m_tdata,
    // status [0]
    output logic                                    o_m_tuser
);

    localparam int OW    = $clog2(MAX_ORDER + 2);
    localparam int AW    = MAX_ORDER;
    localparam int NW    = MAX_ORDER + 1;
    localparam int DEPTH = (2 << MAX_ORDER) - 1;
    localparam int ODW   = ((MAX_ORDER + 7) / 8) * 8;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ARD   = 3'd2;
    localparam logic [2:0] S_ACHK  = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_FRD   = 3'd5;
    localparam logic [2:0] S_FCHK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [OW-1:0] r_o, n_o;
    logic [OW-1:0] r_ord, n_ord;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_status, n_status;
    logic [AW-1:0] r_grant, n_grant;
    logic [NW-1:0] r_clr, n_clr;
    logic          r_mv, n_mv;
    logic          r_m_status, n_m_status;
    logic [AW-1:0] r_m_grant, n_m_grant;

    logic          r_map [DEPTH];
    logic          r_rd;

    logic [OW-1:0] w_sel_o;
    logic [AW-1:0] w_sel_a;
    logic [NW-1:0] w_node;
    logic          w_we;
    logic          w_wd;
    logic [NW-1:0] w_widx;

    logic [NW-1:0] w_size;
    logic [AW-1:0] w_addr_in;
    logic [OW-1:0] w_ord_in;
    logic [AW:0]   w_step;
    logic [AW:0]   w_sum;
    logic [OW-1:0] w_o1;
    logic          w_acc;

    assign w_size    = i_s_tdata[NW-1:0];
    assign w_addr_in = i_s_tdata[NW+AW-1:NW];
    assign w_acc     = i_s_tvalid && o_s_tready;

    // Order of the request: smallest o with 2^o >= size; MAX_ORDER+1 marks too large.
    always_comb begin
        w_ord_in = OW'(MAX_ORDER + 1);
        for (int o = MAX_ORDER; o >= 0; o--) begin
            if ((NW'(1) << o) >= w_size) begin
                w_ord_in = OW'(o);
            end
        end
    end

    // Shared node index unit.
    bba_node_calc #(.MAX_ORDER(MAX_ORDER)) u_node (
        .i_order (w_sel_o),
        .i_addr  (w_sel_a),
        .o_node  (w_node)
    );

    assign w_step = (AW+1)'(1) << r_o;
    assign w_sum  = {1'b0, r_addr} + w_step;
    assign w_o1   = r_o - OW'(1);

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_o        = r_o;
        n_ord      = r_ord;
        n_addr     = r_addr;
        n_status   = r_status;
        n_grant    = r_grant;
        n_clr      = r_clr;
        n_mv       = r_mv;
        n_m_status = r_m_status;
        n_m_grant  = r_m_grant;
        w_sel_o    = r_o;
        w_sel_a    = r_addr;
        w_we       = 1'b0;
        w_wd       = 1'b0;
        w_widx     = w_node;

        if (r_mv && i_m_tready) begin
            n_mv = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                w_we   = 1'b1;
                w_wd   = (r_clr == '0);
                w_widx = r_clr;
                n_clr  = r_clr + NW'(1);
                if (r_clr == NW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_status = BBA_ST_NOSPC;
                    n_grant  = '0;
                    n_o      = w_ord_in;
                    n_ord    = w_ord_in;
                    if (w_ord_in > OW'(MAX_ORDER)) begin
                        n_state = S_DONE;
                    end else if (i_s_tuser == BBA_CMD_ALLOC) begin
                        n_addr  = '0;
                        n_state = S_ARD;
                    end else begin
                        n_addr  = w_addr_in & ~((AW'(1) << w_ord_in) - AW'(1));
                        n_state = S_FRD;
                    end
                end
            end
            S_ARD: begin
                n_state = S_ACHK;
            end
            S_ACHK: begin
                if (r_rd) begin
                    // Take this block; split down if it is larger than asked.
                    w_we = 1'b1;
                    w_wd = 1'b0;
                    if (r_o == r_ord) begin
                        n_status = BBA_ST_OK;
                        n_grant  = r_addr;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SPLIT;
                    end
                end else if (w_sum[AW]) begin
                    // Level exhausted: move to the next larger order.
                    n_addr = '0;
                    if (r_o == OW'(MAX_ORDER)) begin
                        n_state = S_DONE;
                    end else begin
                        n_o     = r_o + OW'(1);
                        n_state = S_ARD;
                    end
                end else begin
                    n_addr  = w_sum[AW-1:0];
                    n_state = S_ARD;
                end
            end
            S_SPLIT: begin
                // Free the upper half at the next lower order.
                w_sel_o = w_o1;
                w_sel_a = r_addr | (AW'(1) << w_o1);
                w_we    = 1'b1;
                w_wd    = 1'b1;
                n_o     = w_o1;
                if (w_o1 == r_ord) begin
                    n_status = BBA_ST_OK;
                    n_grant  = r_addr;
                    n_state  = S_DONE;
                end
            end
            S_FRD: begin
                if (r_o == OW'(MAX_ORDER)) begin
                    w_we     = 1'b1;
                    w_wd     = 1'b1;
                    n_status = BBA_ST_OK;
                    n_state  = S_DONE;
                end else begin
                    w_sel_a = r_addr ^ (AW'(1) << r_o);
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (r_rd) begin
                    // Buddy free: absorb it and climb one order.
                    w_sel_a = r_addr ^ (AW'(1) << r_o);
                    w_we    = 1'b1;
                    w_wd    = 1'b0;
                    n_addr  = r_addr & ~(AW'(1) << r_o);
                    n_o     = r_o + OW'(1);
                    n_state = S_FRD;
                end else begin
                    w_we     = 1'b1;
                    w_wd     = 1'b1;
                    n_status = BBA_ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_mv || i_m_tready) begin
                    n_mv       = 1'b1;
                    n_m_status = r_status;
                    n_m_grant  = r_grant;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_mv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_mv    <= n_mv;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_o        <= n_o;
        r_ord      <= n_ord;
        r_addr     <= n_addr;
        r_status   <= n_status;
        r_grant    <= n_grant;
        r_m_status <= n_m_status;
        r_m_grant  <= n_m_grant;
    end

    // Free-map memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_widx] <= w_wd;
        end
        r_rd <= r_map[w_node];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = ODW'(r_m_grant);
    assign o_m_tuser  = r_m_status;

endmodule

// ----- rtl/bba_checker.sv -----
// Port-level checker for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_core_defines.svh.
`timescale 1ns / 1ps
`include "buddy_block_allocator_core_defines.svh"

module bba_checker
    import bba_pkg::*;
#(
    parameter int MAX_ORDER = BBA_MAX_ORDER
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic [((2*MAX_ORDER+1+7)/8)*8-1:0] i_s_tdata,
    input logic                               i_s_tuser,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [((MAX_ORDER+7)/8)*8-1:0]     o_m_tdata,
    input logic                               o_m_tuser
);

    // A stalled result beat stays offered.
    `BBA_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result beat dropped")

    // In the cycle after it takes a beat, the block is not ready.
    `BBA_ASSERT_NEXT(a_busy, i_s_tvalid && o_s_tready, !o_s_tready, "ready right after accept")

    // A failed request reports address zero.
    `BBA_ASSERT_SAME(a_fail_zero, o_m_tvalid && (o_m_tuser == BBA_ST_NOSPC), o_m_tdata == '0,
        "nonzero address on failure")

endmodule

bind buddy_block_allocator_core bba_checker #(.MAX_ORDER(MAX_ORDER)) u_bba_checker (.*);
